// ===== design/sc_pkg.sv =====
// ----------------------------------------------------------------------------
// sc_pkg
// Request types and cell control group for the sparse compact sort block.
// ----------------------------------------------------------------------------
`default_nettype none

package sc_pkg;

    localparam int PORT_COL_W = 10;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 6;

    typedef struct packed {
        logic [PORT_COL_W-1:0]     column_index;
        logic signed [VALUE_W-1:0] element_value;
        logic                      end_of_vector;
    } sc_in_t;

    typedef struct packed {
        logic [PORT_COL_W-1:0]     out_column;
        logic signed [VALUE_W-1:0] out_value;
        logic [COUNT_W-1:0]        nonzero_count;
        logic                      final_entry;
        logic                      none_found;
        logic                      overflowed;
    } sc_out_t;

    // per-cell control: insert the broadcast pair, shift toward cell 0,
    // and whether this cell currently holds a kept pair
    typedef struct packed {
        logic insert;
        logic shift;
        logic occupied;
    } sc_ctrl_t;

endpackage

`default_nettype wire

// ===== design/sparse_compact_sort.sv =====
// ----------------------------------------------------------------------------
// sparse_compact_sort
// Dense-to-sparse vector compactor with results sorted by column.
// ----------------------------------------------------------------------------
// Dense elements are taken one per cycle. Nonzero pairs drop into a chain of
// CAPACITY cells, each comparing its column with the incoming one in the same
// cycle, so insertion never stalls the input. The element flagged end_of_vector
// is inserted too, after which input stalls while the chain drains out of
// cell 0: N results for N kept pairs (one result for an empty vector), one
// per cycle while m_ready is high. Pairs past CAPACITY are dropped and every
// result of that vector carries overflowed. Store contents are not reset; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_compact_sort
    import sc_pkg::*;
#(
    parameter int CAPACITY    = 32,
    parameter int COLUMN_BITS = 10
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire sc_in_t  s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output sc_out_t      m_data
);

    localparam int KEY_W = (COLUMN_BITS < PORT_COL_W) ? COLUMN_BITS : PORT_COL_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             ovf_reg, ovf_next;

    logic s_fire, m_fire, nonzero, has_room, do_insert, do_shift, last_out;

    logic [KEY_W-1:0]   new_col;
    logic [VALUE_W-1:0] new_val;

    sc_ctrl_t           ctrl [CAPACITY];
    logic               ins  [CAPACITY];
    logic [KEY_W-1:0]   col  [CAPACITY];
    logic [VALUE_W-1:0] val  [CAPACITY];

    logic [CNT_W+COUNT_W-1:0] count_wide;
    logic [PORT_COL_W+KEY_W-1:0] col_wide;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DRAIN);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign new_col  = s_data.column_index[KEY_W-1:0];
    assign new_val  = s_data.element_value;
    assign nonzero  = (s_data.element_value != '0);
    assign has_room = (count_reg < CNT_W'(CAPACITY));
    assign do_insert = s_fire && nonzero && has_room;
    assign do_shift  = m_fire;
    assign last_out  = (count_reg == '0) || (rem_reg == CNT_W'(1));

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic               l_ins;
        logic [KEY_W-1:0]   l_col, r_col;
        logic [VALUE_W-1:0] l_val, r_val;

        assign ctrl[i].insert   = do_insert;
        assign ctrl[i].shift    = do_shift;
        assign ctrl[i].occupied = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_first
            assign l_ins = 1'b0;
            assign l_col = '0;
            assign l_val = '0;
        end else begin : g_mid
            assign l_ins = ins[i-1];
            assign l_col = col[i-1];
            assign l_val = val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign r_col = '0;
            assign r_val = '0;
        end else begin : g_inner
            assign r_col = col[i+1];
            assign r_val = val[i+1];
        end

        sc_cell #(.KEY_W(KEY_W)) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl[i]),
            .new_col   (new_col),
            .new_val   (new_val),
            .left_ins  (l_ins),
            .left_col  (l_col),
            .left_val  (l_val),
            .right_col (r_col),
            .right_val (r_val),
            .ins       (ins[i]),
            .col       (col[i]),
            .val       (val[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (do_insert) begin
                        count_next = count_reg + CNT_W'(1);
                    end else if (nonzero) begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.end_of_vector) begin
                        state_next = ST_DRAIN;
                        rem_next   = count_next;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_fire) begin
                    if (last_out) begin
                        state_next = ST_IDLE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        rem_next = rem_reg - CNT_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, count_reg};
    assign col_wide   = {{PORT_COL_W{1'b0}}, col[0]};

    always_comb begin
        m_data.out_column    = col_wide[PORT_COL_W-1:0];
        m_data.out_value     = val[0];
        m_data.nonzero_count = count_wide[COUNT_W-1:0];
        m_data.final_entry   = last_out;
        m_data.none_found    = (count_reg == '0);
        m_data.overflowed    = ovf_reg;
        if (count_reg == '0) begin
            m_data.out_column = '0;
            m_data.out_value  = '0;
        end
    end

endmodule

`default_nettype wire

// ===== design/sc_cell.sv =====
// ----------------------------------------------------------------------------
// sc_cell
// One slot of the insertion chain: holds a column/value pair, takes the new
// pair or its left neighbor's pair on insert, and its right neighbor's pair
// on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module sc_cell
    import sc_pkg::*;
#(
    parameter int KEY_W = 10
) (
    input  wire logic               aclk,
    input  wire sc_ctrl_t           ctrl,
    input  wire logic [KEY_W-1:0]   new_col,
    input  wire logic [VALUE_W-1:0] new_val,
    input  wire logic               left_ins,
    input  wire logic [KEY_W-1:0]   left_col,
    input  wire logic [VALUE_W-1:0] left_val,
    input  wire logic [KEY_W-1:0]   right_col,
    input  wire logic [VALUE_W-1:0] right_val,
    output logic                    ins,
    output logic [KEY_W-1:0]        col,
    output logic [VALUE_W-1:0]      val
);

    logic [KEY_W-1:0]   col_reg, col_next;
    logic [VALUE_W-1:0] val_reg, val_next;

    // empty slots and slots with a larger column move right; equal stays
    assign ins = !ctrl.occupied || (col_reg > new_col);

    always_comb begin
        col_next = col_reg;
        val_next = val_reg;
        if (ctrl.shift) begin
            col_next = right_col;
            val_next = right_val;
        end else if (ctrl.insert) begin
            if (left_ins) begin
                col_next = left_col;
                val_next = left_val;
            end else if (ins) begin
                col_next = new_col;
                val_next = new_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
        val_reg <= val_next;
    end

    assign col = col_reg;
    assign val = val_reg;

endmodule

`default_nettype wire

// ===== design/sc_checker.sv =====
// ----------------------------------------------------------------------------
// sc_checker
// Port-level checks for sparse_compact_sort, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sc_checker
    import sc_pkg::*;
(
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    s_valid,
    input wire logic    s_ready,
    input wire sc_in_t  s_data,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire sc_out_t m_data
);

    // input is held off while results drain
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while results pending");

    // the end element starts the result run on the next cycle
    a_end_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.end_of_vector) |=> m_valid)
        else $error("no result after end of vector");

    // a run does not break before its final entry
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.final_entry) |=> m_valid)
        else $error("result run ended early");

    // the empty-vector result is a lone zero entry
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.none_found) |->
        (m_data.final_entry && m_data.out_value == 0 && m_data.nonzero_count == 0))
        else $error("malformed empty-vector result");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind sparse_compact_sort sc_checker u_sc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
